FILE: src/sld_pkg.sv
// Package for the start/length/body deframer.
// Holds the phase, number-scan and error types, the result word type and helper functions.
// No dependencies.
package sld_pkg;

  // Width of the accepted body length (lengths above 2^LENGTH_BITS - 1 are rejected).
  localparam int unsigned LENGTH_BITS = 31;
  // Fixed width of the body length result field.
  localparam int unsigned OUT_LEN_W   = 31;
  localparam int unsigned START_LEN   = 5;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_LEN   = 2'd1,
    PH_BODY  = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    SC_WS   = 2'd0,
    SC_SIGN = 2'd1,
    SC_DIG  = 2'd2,
    SC_TAIL = 2'd3
  } scan_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_START = 2'd1,
    ERR_LEN   = 2'd2,
    ERR_BODY  = 2'd3
  } err_t;

  typedef struct packed {
    logic [7:0]           body_byte;
    logic                 body_valid;
    logic                 message_done;
    err_t                 error_code;
    logic [OUT_LEN_W-1:0] body_length;
  } res_t;

  // Letters of the start word, upper case.
  function automatic logic [7:0] start_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h53; // S
      3'd1:    ch = 8'h54; // T
      3'd2:    ch = 8'h41; // A
      3'd3:    ch = 8'h52; // R
      3'd4:    ch = 8'h54; // T
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'd32) : c;
  endfunction

endpackage

FILE: src/start_length_body_deframer.sv
// Top level of the start/length/body deframer: parser state, result register and skid word.
// Depends on sld_pkg.
//
// The deframer takes one byte per cycle and returns one result word per byte, in order.
// The parser state is updated in the cycle a byte is accepted, using a short path of
// compares and one multiply-by-ten on the length accumulator; the result goes into an
// output register backed by a one-word skid register, so in_ready only drops when both
// hold words not yet taken. A result is registered in the output word, or in the skid word
// while that waits; one byte per cycle is sustained while the consumer keeps up. Errors and
// done stay until reset; meanwhile, further bytes still produce (repeating) result words.
module start_length_body_deframer
  import sld_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_body_byte,
  output logic                 out_body_valid,
  output logic                 out_message_done,
  output logic [1:0]           out_error_code,
  output logic [OUT_LEN_W-1:0] out_body_length
);

  localparam int unsigned ACC_W = LENGTH_BITS + 4;

  phase_t                 phase_r,      phase_nxt;
  logic [2:0]             match_r,      match_nxt;
  scan_t                  scan_r,       scan_nxt;
  logic                   neg_r,        neg_nxt;
  logic                   digit_seen_r, digit_seen_nxt;
  logic                   ovf_r,        ovf_nxt;
  logic [LENGTH_BITS-1:0] len_r,        len_nxt;
  logic [LENGTH_BITS-1:0] count_r,      count_nxt;
  err_t                   err_r,        err_nxt;

  res_t                   res_new;
  res_t                   out_word_r,   out_word_nxt;
  logic                   out_valid_r,  out_valid_nxt;
  res_t                   skid_word_r,  skid_word_nxt;
  logic                   skid_valid_r, skid_valid_nxt;

  logic                   in_fire;
  logic                   out_fire;
  logic                   body_ok;
  logic [7:0]             c;
  logic [ACC_W-1:0]       acc_ext;
  logic [ACC_W-1:0]       acc_prod;

  assign c        = in_data_byte;
  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  // Length accumulator times ten plus the digit, with headroom for the overflow check.
  assign acc_ext  = ACC_W'(len_r);
  assign acc_prod = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(c[3:0]);

  // Next parser state for the byte on the input.
  always_comb begin
    phase_nxt      = phase_r;
    match_nxt      = match_r;
    scan_nxt       = scan_r;
    neg_nxt        = neg_r;
    digit_seen_nxt = digit_seen_r;
    ovf_nxt        = ovf_r;
    len_nxt        = len_r;
    count_nxt      = count_r;
    err_nxt        = err_r;
    body_ok        = 1'b0;
    if (err_r == ERR_NONE) begin
      case (phase_r)
        PH_START: begin
          if (c == CH_NEWLINE) begin
            if (match_r == 3'(START_LEN)) begin
              phase_nxt = PH_LEN;
            end else begin
              err_nxt = ERR_START;
            end
          end else if ((match_r < 3'(START_LEN)) && (to_upper(c) == start_char(match_r))) begin
            match_nxt = match_r + 3'd1;
          end else begin
            err_nxt = ERR_START;
          end
        end
        PH_LEN: begin
          if (c == CH_NEWLINE) begin
            if (!digit_seen_r || ovf_r || (neg_r && (len_r != '0))) begin
              err_nxt = ERR_LEN;
            end else begin
              phase_nxt = PH_BODY;
              count_nxt = '0;
            end
          end else begin
            case (scan_r)
              SC_WS: begin
                if (is_space(c)) begin
                  scan_nxt = SC_WS;
                end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
                  neg_nxt  = (c == CH_MINUS);
                  scan_nxt = SC_SIGN;
                end else if (is_digit(c)) begin
                  scan_nxt = SC_DIG;
                end else begin
                  scan_nxt = SC_TAIL;
                end
              end
              SC_SIGN, SC_DIG: begin
                scan_nxt = is_digit(c) ? SC_DIG : SC_TAIL;
              end
              default: begin
                scan_nxt = scan_r;
              end
            endcase
            // A digit is taken in any stage but the trailing one, except after non-sign junk.
            if (is_digit(c) && (scan_r != SC_TAIL)) begin
              digit_seen_nxt = 1'b1;
              if (!ovf_r) begin
                if (acc_prod[ACC_W-1:LENGTH_BITS] != '0) begin
                  ovf_nxt = 1'b1;
                end else begin
                  len_nxt = acc_prod[LENGTH_BITS-1:0];
                end
              end
            end
          end
        end
        PH_BODY: begin
          if (count_r >= len_r) begin
            err_nxt = ERR_BODY;
          end else begin
            count_nxt = count_r + 1'b1;
            body_ok   = 1'b1;
            if ((count_r + 1'b1) == len_r) begin
              phase_nxt = PH_DONE;
            end
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // Result word for the byte on the input, taken from the updated state.
  always_comb begin
    res_new.body_byte    = body_ok ? c : 8'h00;
    res_new.body_valid   = body_ok;
    res_new.message_done = (phase_nxt == PH_DONE);
    res_new.error_code   = err_nxt;
    res_new.body_length  = ((phase_nxt == PH_BODY) || (phase_nxt == PH_DONE))
                           ? OUT_LEN_W'(len_nxt) : '0;
  end

  // Output register with a skid word behind it.
  always_comb begin
    out_word_nxt   = out_word_r;
    out_valid_nxt  = out_valid_r;
    skid_word_nxt  = skid_word_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_fire) begin
      out_word_nxt   = skid_valid_r ? skid_word_r : res_new;
      out_valid_nxt  = skid_valid_r || in_fire;
      skid_valid_nxt = 1'b0;
    end else if (in_fire) begin
      skid_word_nxt  = res_new;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_START;
      match_r      <= '0;
      scan_r       <= SC_WS;
      neg_r        <= 1'b0;
      digit_seen_r <= 1'b0;
      ovf_r        <= 1'b0;
      len_r        <= '0;
      count_r      <= '0;
      err_r        <= ERR_NONE;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r      <= phase_nxt;
        match_r      <= match_nxt;
        scan_r       <= scan_nxt;
        neg_r        <= neg_nxt;
        digit_seen_r <= digit_seen_nxt;
        ovf_r        <= ovf_nxt;
        len_r        <= len_nxt;
        count_r      <= count_nxt;
        err_r        <= err_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_body_byte    = out_word_r.body_byte;
  assign out_body_valid   = out_word_r.body_valid;
  assign out_message_done = out_word_r.message_done;
  assign out_error_code   = out_word_r.error_code;
  assign out_body_length  = out_word_r.body_length;

  // The skid word is only ever filled behind a waiting output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held without an output word");

  // Once set, an error never changes until reset.
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ERR_NONE) |=> (err_r == $past(err_r)))
    else $error("sticky error changed");

  // The done phase is only held with the body count equal to the length.
  a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE) |-> (count_r == len_r))
    else $error("done phase with body count short of length");

  // A body word or done flag never appears together with an error.
  a_body_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_word_r.body_valid || out_word_r.message_done))
      |-> (out_word_r.error_code == ERR_NONE))
    else $error("body word or done reported with an error");

endmodule

FILE: tb/deframer_checker.sv
// Checker for the start/length/body deframer: follows the parser from accepted input words,
// predicts one result word per byte and compares it with every accepted output word.
// Depends on sld_pkg.
module deframer_checker
  import sld_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [7:0]           out_body_byte,
  input  logic                 out_body_valid,
  input  logic                 out_message_done,
  input  logic [1:0]           out_error_code,
  input  logic [OUT_LEN_W-1:0] out_body_length,
  output int                   fail_count,
  output int                   pending
);

  localparam longint unsigned LEN_MAX   = (64'd1 << LENGTH_BITS) - 1;
  localparam logic [39:0]     WORD_TEXT = "START";
  localparam logic [7:0]      CH_ZERO   = 8'h30;
  localparam logic [7:0]      CH_NINE   = 8'h39;

  // Parser state as the block should hold it.
  phase_t                 phase_q;
  logic [2:0]             letters_matched;
  scan_t                  scan_q;
  logic                   minus_seen;
  logic                   digits_seen;
  logic                   too_big;
  logic [LENGTH_BITS-1:0] length_acc;
  logic [LENGTH_BITS-1:0] bytes_passed;
  err_t                   err_q;

  res_t results_due[$];
  int   fails = 0;

  assign fail_count = fails;

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D;
  endfunction

  task automatic deframe_byte(input logic [7:0] c, output res_t r);
    logic            take;
    logic            is_dig;
    logic [7:0]      up;
    longint unsigned grown;
    take   = 1'b0;
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    up     = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    if (err_q == ERR_NONE && phase_q != PH_DONE) begin
      case (phase_q)
        PH_START: begin
          if (c == CH_NEWLINE) begin
            if (letters_matched == 3'd5) phase_q = PH_LEN;
            else err_q = ERR_START;
          end else if (letters_matched < 3'd5 &&
                       up == WORD_TEXT[8*(4-letters_matched) +: 8]) begin
            letters_matched = letters_matched + 3'd1;
          end else begin
            err_q = ERR_START;
          end
        end
        PH_LEN: begin
          if (c == CH_NEWLINE) begin
            if (!digits_seen || too_big || (minus_seen && length_acc != '0)) begin
              err_q = ERR_LEN;
            end else begin
              phase_q      = PH_BODY;
              bytes_passed = '0;
            end
          end else if (scan_q != SC_TAIL) begin
            if (scan_q == SC_WS && is_blank(c)) begin
              // Leading whitespace is skipped.
            end else if (scan_q == SC_WS && (c == CH_PLUS || c == CH_MINUS)) begin
              minus_seen = (c == CH_MINUS);
              scan_q     = SC_SIGN;
            end else if (is_dig) begin
              digits_seen = 1'b1;
              // Once the value has overflowed, further digits still count as seen but are not added.
              if (!too_big) begin
                grown = 64'(length_acc) * 64'd10 + 64'(c - CH_ZERO);
                if (grown > LEN_MAX) too_big = 1'b1;
                else length_acc = grown[LENGTH_BITS-1:0];
              end
              scan_q = SC_DIG;
            end else begin
              scan_q = SC_TAIL;
            end
          end
        end
        default: begin
          if (bytes_passed >= length_acc) begin
            err_q = ERR_BODY;
          end else begin
            bytes_passed = bytes_passed + 1'b1;
            take         = 1'b1;
            if (bytes_passed == length_acc) phase_q = PH_DONE;
          end
        end
      endcase
    end
    r.body_byte    = take ? c : 8'h00;
    r.body_valid   = take;
    r.message_done = (phase_q == PH_DONE);
    r.error_code   = err_q;
    r.body_length  = (phase_q == PH_BODY || phase_q == PH_DONE) ?
                     OUT_LEN_W'(length_acc) : '0;
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    res_t got;
    logic wrong;
    if (!rst_n) begin
      phase_q         = PH_START;
      letters_matched = 3'd0;
      scan_q          = SC_WS;
      minus_seen      = 1'b0;
      digits_seen     = 1'b0;
      too_big         = 1'b0;
      length_acc      = '0;
      bytes_passed    = '0;
      err_q           = ERR_NONE;
      results_due.delete();
    end else begin
      if (in_valid && in_ready) begin
        deframe_byte(in_data_byte, want);
        results_due.insert(results_due.size(), want);
      end
      if (out_valid && out_ready) begin
        got.body_byte    = out_body_byte;
        got.body_valid   = out_body_valid;
        got.message_done = out_message_done;
        got.error_code   = err_t'(out_error_code);
        got.body_length  = out_body_length;
        if (results_due.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("mismatch: output word with no byte waiting: byte %02h valid %0d",
                     got.body_byte, got.body_valid);
        end else begin
          want  = results_due.pop_front();
          wrong = (got.body_byte !== want.body_byte) ||
                  (got.body_valid !== want.body_valid) ||
                  (got.message_done !== want.message_done) ||
                  (got.error_code !== want.error_code) ||
                  (got.body_length !== want.body_length);
          if (wrong) begin
            fails++;
            if (fails <= 10)
              $display({"mismatch: expected byte %02h valid %0d done %0d err %0d len %0d, ",
                        "got byte %02h valid %0d done %0d err %0d len %0d"},
                       want.body_byte, want.body_valid, want.message_done,
                       want.error_code, want.body_length,
                       got.body_byte, got.body_valid, got.message_done,
                       got.error_code, got.body_length);
          end
        end
      end
    end
    pending <= results_due.size();
  end

endmodule

FILE: tb/start_length_body_deframer_test.sv
// Top of the deframer testbench: builds one byte stream per run, drives it with varying
// idling and back-pressure, and gives the verdict from the checker's failure count.
// Depends on sld_pkg, start_length_body_deframer and deframer_checker.
module start_length_body_deframer_test;
  import sld_pkg::*;

  localparam int              CYCLE_LIMIT = 400000;
  localparam int              STREAM_MIN  = 1000;
  localparam longint unsigned LEN_MAX     = (64'd1 << LENGTH_BITS) - 1;
  localparam logic [39:0]     BLANKS      = {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           in_data_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic [7:0]           out_body_byte;
  logic                 out_body_valid;
  logic                 out_message_done;
  logic [1:0]           out_error_code;
  logic [OUT_LEN_W-1:0] out_body_length;

  int         fail_count;
  int         pending;
  logic [7:0] stream_q[$];
  int         tx_idle_pct = 0;
  int         rx_stall_pct = 0;
  logic       hold_req = 1'b0;
  int         cycle_count = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  start_length_body_deframer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_body_byte    (out_body_byte),
    .out_body_valid   (out_body_valid),
    .out_message_done (out_message_done),
    .out_error_code   (out_error_code),
    .out_body_length  (out_body_length)
  );

  deframer_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_body_byte    (out_body_byte),
    .out_body_valid   (out_body_valid),
    .out_message_done (out_message_done),
    .out_error_code   (out_error_code),
    .out_body_length  (out_body_length),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  task automatic add_byte(input logic [7:0] b);
    stream_q.insert(stream_q.size(), b);
  endtask

  task automatic push_text(input string s);
    for (int k = 0; k < s.len(); k++) add_byte(s[k]);
  endtask

  function automatic logic [7:0] any_but_newline();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_NEWLINE);
    return b;
  endfunction

  task automatic add_noise(input int n);
    repeat (n) add_byte(8'($urandom_range(0, 255)));
  endtask

  // The start word with each letter in a random case.
  task automatic add_start_line();
    logic [39:0] word;
    word = "START";
    for (int k = 4; k >= 0; k--)
      add_byte(word[8*k +: 8] | ($urandom_range(0, 1) ? 8'h20 : 8'h00));
    add_byte(CH_NEWLINE);
  endtask

  // Only one message can be seen per run, since errors and done hold until reset;
  // most runs take a well-formed message with a long body.
  task automatic build_stream();
    longint unsigned body_len;
    int              pick;
    int              k;
    int              body_n;
    logic [7:0]      b;
    logic [39:0]     word;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      add_start_line();
      pick = $urandom_range(0, 99);
      if (pick < 80) body_len = $urandom_range(700, 1000);
      else if (pick < 88) body_len = $urandom_range(1, 6);
      else if (pick < 94) body_len = 0;
      else body_len = LEN_MAX;
      repeat ($urandom_range(0, 5)) begin
        k = $urandom_range(0, 4);
        add_byte(BLANKS[8*k +: 8]);
      end
      // A minus sign in front of zero still gives an accepted length of zero.
      if (body_len == 0 && $urandom_range(0, 1)) add_byte(CH_MINUS);
      else if ($urandom_range(0, 2) == 0) add_byte(CH_PLUS);
      repeat ($urandom_range(0, 2)) push_text("0");
      push_text($sformatf("%0d", body_len));
      if ($urandom_range(0, 2) == 0) begin
        do b = any_but_newline(); while (b >= 8'h30 && b <= 8'h39);
        add_byte(b);
        repeat ($urandom_range(0, 2)) add_byte(any_but_newline());
      end
      add_byte(CH_NEWLINE);
      body_n = (body_len == 0) ? 3 : (body_len > 1000) ? 980 : int'(body_len);
      for (k = 0; k < body_n; k++) begin
        case (k)
          0:       add_byte(8'h00);
          1:       add_byte(8'hFF);
          2:       add_byte(CH_NEWLINE);
          default: add_byte(8'($urandom_range(0, 255)));
        endcase
      end
      add_noise(24);
    end else if (pick < 85) begin
      // Broken start line: a wrong letter, an early newline or one letter too many.
      word = "START";
      body_n = $urandom_range(0, 5);
      for (k = 0; k < body_n; k++) add_byte(word[8*(4-k) +: 8]);
      if (body_n < 5 && $urandom_range(0, 1)) begin
        add_byte(CH_NEWLINE);
      end else begin
        do b = any_but_newline();
        while (body_n < 5 && (b & 8'hDF) == word[8*(4-body_n) +: 8]);
        add_byte(b);
      end
      add_noise(40);
    end else begin
      add_start_line();
      case ($urandom_range(0, 4))
        0: ;
        1: begin
          add_byte(8'h20);
          add_byte(8'h09);
          add_byte(CH_PLUS);
        end
        2: push_text("-x5");
        3: begin
          add_byte(CH_MINUS);
          push_text($sformatf("%0d", $urandom_range(1, 999)));
        end
        default: begin
          if ($urandom_range(0, 1))
            push_text($sformatf("%0d", LEN_MAX + 1 + $urandom_range(0, 1000)));
          else
            push_text("99999999999999999999");
        end
      endcase
      add_byte(CH_NEWLINE);
      add_noise(40);
    end
    // Short messages are followed by bytes that the block ignores, to keep the run long.
    if (stream_q.size() < STREAM_MIN) add_noise(STREAM_MIN - stream_q.size());
  endtask

  initial begin : sender
    int n_items;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = 8'h00;
    build_stream();
    n_items = stream_q.size();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < n_items; i++) begin
      case (i * 4 / n_items)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 83; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 83; end
        default: begin tx_idle_pct = 23; rx_stall_pct = 23; end
      endcase
      // The receiver goes quiet for a while here; the sender keeps offering words.
      if (i == n_items / 8) hold_req = 1'b1;
      if (i == n_items / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      while ($urandom_range(0, 99) < tx_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid     <= 1'b1;
      in_data_byte <= stream_q[i];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin : receiver
    logic hold_taken;
    int   hold_left;
    hold_taken = 1'b0;
    hold_left  = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = 64;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

endmodule
